// ===== src/dlt_pkg.sv =====
package dlt_pkg;

    // Fixed field widths of the ports
    localparam int ADDR_BITS  = 15;
    localparam int CHAN_BITS  = 16;
    localparam int COORD_BITS = 16;
    localparam int COL_BITS   = 8;
    localparam int ROW_BITS   = 7;
    localparam int WREG_BITS  = 9;
    localparam int HREG_BITS  = 8;

    localparam logic [WREG_BITS-1:0] MAP_WIDTH_RST  = 9'd256;
    localparam logic [HREG_BITS-1:0] MAP_HEIGHT_RST = 8'd128;

    // Angle arithmetic: turns in units of 2^-18
    localparam int TURN_BITS   = 18;
    localparam int ANG_BITS    = 21;
    localparam int DIR_BITS    = 18;
    localparam int CORDIC_W    = 40;
    localparam int GUARD_SHIFT = 20;
    localparam logic signed [ANG_BITS-1:0] HALF_TURN = 21'sd131072;

    // Integer square root of x^2+y^2
    localparam int SQ_BITS  = 32;
    localparam int SQ_STEPS = 16;
    localparam int ROOT_BITS = 17;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_LOOKUP = 1'b1
    } t_req;

    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 lookup;
        logic                 wr_ok;
        logic [ADDR_BITS-1:0] addr;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_side;

    function automatic logic signed [ANG_BITS-1:0] atan_turn(input int i);
        logic signed [ANG_BITS-1:0] v;
        case (i)
            0:       v = 21'sd32768;
            1:       v = 21'sd19344;
            2:       v = 21'sd10221;
            3:       v = 21'sd5188;
            4:       v = 21'sd2604;
            5:       v = 21'sd1303;
            6:       v = 21'sd652;
            7:       v = 21'sd326;
            8:       v = 21'sd163;
            9:       v = 21'sd81;
            10:      v = 21'sd41;
            11:      v = 21'sd20;
            12:      v = 21'sd10;
            13:      v = 21'sd5;
            14:      v = 21'sd3;
            15:      v = 21'sd1;
            16:      v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/dlt_cordic.sv =====
module dlt_cordic
    import dlt_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [DIR_BITS-1:0] i_x,
    input  logic signed [DIR_BITS-1:0] i_y,
    output logic signed [ANG_BITS-1:0] o_ang
);

    logic signed [CORDIC_W-1:0] r_x [0:STEPS];
    logic signed [CORDIC_W-1:0] r_y [0:STEPS];
    logic signed [ANG_BITS-1:0] r_a [0:STEPS];

    logic signed [CORDIC_W-1:0] xe, ye, n_x0, n_y0;
    logic signed [ANG_BITS-1:0] n_a0;

    // Turn a left-half vector by a half turn, then scale up
    always_comb begin
        xe = CORDIC_W'(i_x);
        ye = CORDIC_W'(i_y);
        if (i_x[DIR_BITS-1]) begin
            n_x0 = (-xe) <<< GUARD_SHIFT;
            n_y0 = (-ye) <<< GUARD_SHIFT;
            n_a0 = HALF_TURN;
        end else begin
            n_x0 = xe <<< GUARD_SHIFT;
            n_y0 = ye <<< GUARD_SHIFT;
            n_a0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_a[0] <= n_a0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [CORDIC_W-1:0] dx, dy, n_x, n_y;
        logic signed [ANG_BITS-1:0] n_a;
        always_comb begin
            dx = r_y[k] >>> k;
            dy = r_x[k] >>> k;
            n_x = r_x[k];
            n_y = r_y[k];
            n_a = r_a[k];
            if (r_y[k] > 0) begin
                n_x = r_x[k] + dx;
                n_y = r_y[k] - dy;
                n_a = r_a[k] + atan_turn(k);
            end else if (r_y[k] < 0) begin
                n_x = r_x[k] - dx;
                n_y = r_y[k] + dy;
                n_a = r_a[k] - atan_turn(k);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1] <= n_x;
                r_y[k+1] <= n_y;
                r_a[k+1] <= n_a;
            end
        end
    end

    assign o_ang = r_a[STEPS];

endmodule

// ===== src/dlt_isqrt.sv =====
module dlt_isqrt
    import dlt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SQ_BITS-1:0]   i_val,
    output logic [ROOT_BITS-1:0] o_root
);

    logic [SQ_BITS-1:0] r_v [0:SQ_STEPS-1];
    logic [SQ_BITS-1:0] r_q [0:SQ_STEPS-1];

    // One result bit per stage, bit weight 4^(15-k)
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [SQ_BITS-1:0] BIT = 32'h4000_0000 >> (2 * k);
        logic [SQ_BITS-1:0] sv, sq, trial, n_v, n_q;
        if (k == 0) begin : g_first
            assign sv = i_val;
            assign sq = '0;
        end else begin : g_next
            assign sv = r_v[k-1];
            assign sq = r_q[k-1];
        end
        always_comb begin
            trial = sq + BIT;
            if (sv >= trial) begin
                n_v = sv - trial;
                n_q = (sq >> 1) + BIT;
            end else begin
                n_v = sv;
                n_q = sq >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k] <= n_v;
                r_q[k] <= n_q;
            end
        end
    end

    assign o_root = r_q[SQ_STEPS-1][ROOT_BITS-1:0];

endmodule

// ===== src/dlt_texel_ram.sv =====
module dlt_texel_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/direction_to_latlong_texel_lookup.sv =====
// Path: a lookup word passes the input and square registers, the sum, the 16-stage root,
// the polar CORDIC, the coordinate and address registers, then the store read.
// Throughput: one word per cycle, writes and lookups alike, in arrival order, while the
// output skid is empty. A texel write lands in the store at the address stage.
// Reset (synchronous, active low) empties the pipeline and output skid and sets
// width 256, height 128; the texel store keeps its contents and needs no clearing.
module direction_to_latlong_texel_lookup
    import dlt_pkg::*;
#(
    parameter int MAX_COLUMNS  = 256,
    parameter int MAX_ROWS     = 128,
    parameter int CHANNEL_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [WREG_BITS-1:0]         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic [ADDR_BITS-1:0]         i_texel_address,
    input  logic [CHAN_BITS-1:0]         i_write_red,
    input  logic [CHAN_BITS-1:0]         i_write_green,
    input  logic [CHAN_BITS-1:0]         i_write_blue,
    input  logic signed [COORD_BITS-1:0] i_dir_x,
    input  logic signed [COORD_BITS-1:0] i_dir_y,
    input  logic signed [COORD_BITS-1:0] i_dir_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [CHAN_BITS-1:0]         o_color_red,
    output logic [CHAN_BITS-1:0]         o_color_green,
    output logic [CHAN_BITS-1:0]         o_color_blue,
    output logic [COL_BITS-1:0]          o_pixel_column,
    output logic [ROW_BITS-1:0]          o_pixel_row
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 3 * CHANNEL_BITS;
    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int CWID  = $clog2(MAX_COLUMNS);
    localparam int RWID  = $clog2(MAX_ROWS);

    localparam int LV_CT  = 1 + CORDIC_STEPS;
    localparam int LV_R   = 2 + SQ_STEPS;
    localparam int LV_CP  = LV_R + 1 + CORDIC_STEPS;
    localparam int LV_ADR = LV_CP + 2;
    localparam int TH_D   = LV_CP - LV_CT;

    logic adv;

    // Configuration registers
    logic [WREG_BITS-1:0] r_map_width;
    logic [HREG_BITS-1:0] r_map_height;
    logic [WW-1:0]        w_sat;
    logic [HW-1:0]        h_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAP_WIDTH_RST;
            r_map_height <= MAP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data[HREG_BITS-1:0];
                default:        r_map_width  <= r_map_width;
            endcase
        end
    end

    always_comb begin
        if (r_map_width == '0) begin
            w_sat = WW'(1);
        end else if (32'(r_map_width) > MAX_COLUMNS) begin
            w_sat = WW'(MAX_COLUMNS);
        end else begin
            w_sat = WW'(r_map_width);
        end
        if (r_map_height == '0) begin
            h_sat = HW'(1);
        end else if (32'(r_map_height) > MAX_ROWS) begin
            h_sat = HW'(MAX_ROWS);
        end else begin
            h_sat = HW'(r_map_height);
        end
    end

    // Valid bits and sideband
    logic [LV_ADR:0] r_vld;
    t_side           r_side [0:LV_ADR];
    t_side           n_side;

    always_comb begin
        n_side.lookup = (i_req_type == REQ_LOOKUP);
        n_side.wr_ok  = (i_req_type == REQ_WRITE) && (32'(i_texel_address) < DEPTH);
        n_side.addr   = i_texel_address;
        n_side.red    = i_write_red;
        n_side.green  = i_write_green;
        n_side.blue   = i_write_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LV_ADR-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k <= LV_ADR; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Direction front end: squares, sum, z delay
    logic signed [COORD_BITS-1:0] r_x0, r_y0;
    logic signed [COORD_BITS-1:0] r_z [0:LV_R];
    logic [SQ_BITS-2:0]           r_xx, r_yy;
    logic [SQ_BITS-1:0]           r_sum;
    logic signed [2*COORD_BITS-1:0] xx, yy;

    assign xx = r_x0 * r_x0;
    assign yy = r_y0 * r_y0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x0 <= i_dir_x;
            r_y0 <= i_dir_y;
            r_z[0] <= i_dir_z;
            for (int k = 1; k <= LV_R; k++) begin
                r_z[k] <= r_z[k-1];
            end
            r_xx  <= xx[SQ_BITS-2:0];
            r_yy  <= yy[SQ_BITS-2:0];
            r_sum <= SQ_BITS'(r_xx) + SQ_BITS'(r_yy);
        end
    end

    logic [ROOT_BITS-1:0] root;

    dlt_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_sum),
        .o_root (root)
    );

    // Azimuth and polar CORDIC units
    logic signed [ANG_BITS-1:0] theta_ang, phi_ang;

    dlt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (DIR_BITS'(r_x0)),
        .i_y   (DIR_BITS'(r_y0)),
        .o_ang (theta_ang)
    );

    dlt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (DIR_BITS'(r_z[LV_R])),
        .i_y   ({1'b0, root}),
        .o_ang (phi_ang)
    );

    logic [TURN_BITS-1:0] r_th [0:TH_D-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_th[0] <= theta_ang[TURN_BITS-1:0];
            for (int k = 1; k < TH_D; k++) begin
                r_th[k] <= r_th[k-1];
            end
        end
    end

    // Angles to raw coordinates
    logic [TURN_BITS-1:0]    phi;
    logic [TURN_BITS+HW-1:0] prod_r;
    logic [TURN_BITS+WW-1:0] prod_c;
    logic [HW:0]             r_row_raw;
    logic [WW-1:0]           r_col_raw;

    always_comb begin
        if (phi_ang < 0) begin
            phi = '0;
        end else if (phi_ang > HALF_TURN) begin
            phi = HALF_TURN[TURN_BITS-1:0];
        end else begin
            phi = phi_ang[TURN_BITS-1:0];
        end
        prod_r = (TURN_BITS+HW)'(phi) * (TURN_BITS+HW)'(h_sat - HW'(1));
        prod_c = (TURN_BITS+WW)'(r_th[TH_D-1]) * (TURN_BITS+WW)'(w_sat - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_row_raw <= prod_r[TURN_BITS+HW-1:TURN_BITS-1];
            r_col_raw <= prod_c[TURN_BITS+WW-1:TURN_BITS];
        end
    end

    // Clamp and form the store address
    logic [CWID-1:0] col_c, r_col, r_ocol;
    logic [RWID-1:0] row_c, r_row, r_orow;
    logic [AW-1:0]   addr_c, r_addr;

    always_comb begin
        if (r_col_raw >= w_sat) begin
            col_c = CWID'(w_sat - WW'(1));
        end else begin
            col_c = CWID'(r_col_raw);
        end
        if (r_row_raw >= (HW+1)'(h_sat)) begin
            row_c = RWID'(h_sat - HW'(1));
        end else begin
            row_c = RWID'(r_row_raw);
        end
        addr_c = AW'(row_c) * AW'(w_sat) + AW'(col_c);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_addr <= addr_c;
            r_row  <= row_c;
            r_col  <= col_c;
            r_orow <= r_row;
            r_ocol <= r_col;
        end
    end

    // Store: writes and reads share one pipeline slot, so order holds
    logic          mem_we;
    logic [DW-1:0] mem_rdata;

    assign mem_we = adv && r_vld[LV_ADR] && r_side[LV_ADR].wr_ok;

    dlt_texel_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(r_side[LV_ADR].addr)),
        .i_wdata ({CHANNEL_BITS'(r_side[LV_ADR].red),
                   CHANNEL_BITS'(r_side[LV_ADR].green),
                   CHANNEL_BITS'(r_side[LV_ADR].blue)}),
        .i_re    (adv),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // Output stage with skid
    logic            r_olk;
    logic            r_skid_v;
    logic [DW-1:0]   r_skid_rgb;
    logic [CWID-1:0] r_skid_col;
    logic [RWID-1:0] r_skid_row;
    logic [DW-1:0]   out_rgb;

    assign adv = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olk    <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (adv) begin
                r_olk <= r_vld[LV_ADR] && r_side[LV_ADR].lookup;
            end
            if (r_skid_v && i_out_ready) begin
                r_skid_v <= 1'b0;
            end else if (adv && r_olk && !i_out_ready) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // Park the shown word when the pipeline moves on without it taken
    always_ff @(posedge i_clk) begin
        if (adv && r_olk && !i_out_ready) begin
            r_skid_rgb <= mem_rdata;
            r_skid_col <= r_ocol;
            r_skid_row <= r_orow;
        end
    end

    assign out_rgb        = r_skid_v ? r_skid_rgb : mem_rdata;
    assign o_out_valid    = r_skid_v || r_olk;
    assign o_in_ready     = adv;
    assign o_color_red    = CHAN_BITS'(out_rgb[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
    assign o_color_green  = CHAN_BITS'(out_rgb[2*CHANNEL_BITS-1:CHANNEL_BITS]);
    assign o_color_blue   = CHAN_BITS'(out_rgb[CHANNEL_BITS-1:0]);
    assign o_pixel_column = COL_BITS'(r_skid_v ? r_skid_col : r_ocol);
    assign o_pixel_row    = ROW_BITS'(r_skid_v ? r_skid_row : r_orow);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_out_ready) |=> !r_skid_v)
        else $error("skid word not released after take");

    a_hold_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> ($stable(r_ocol) && $stable(r_orow) && $stable(r_olk)))
        else $error("pipeline moved while skid full");

endmodule
